/* hdl/bertlv_pkg.sv */
// Shared constants, codes and types of the BER-TLV stream parser.
package bertlv_pkg;

   // Sizing of the parser
   localparam int MAX_DEPTH     = 8;
   localparam int MAX_TAG_BYTES = 4;
   localparam int MAX_LEN_BYTES = 4;

   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int TAG_CNT_W = $clog2(MAX_TAG_BYTES + 1);
   localparam int LEFT_W    = $clog2(MAX_LEN_BYTES + 1);

   // Field widths of the channels
   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 32;
   localparam int KIND_W      = 2;
   localparam int LEVEL_W     = 4;
   localparam int TAG_BYTES_W = 3;
   localparam int ERR_W       = 3;
   localparam int LIMIT_W     = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 3;

   // Byte classification
   localparam logic [KIND_W-1:0] KIND_TAG    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LENGTH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SKIP   = 2'd3;

   // Sticky error codes
   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_TAG_LONG  = 3'd1;
   localparam logic [ERR_W-1:0] ERR_LEN_LONG  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_OVERRUN   = 3'd3;
   localparam logic [ERR_W-1:0] ERR_TOO_DEEP  = 3'd4;
   localparam logic [ERR_W-1:0] ERR_TRUNCATED = 3'd5;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_LEN_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEST_EN   = 1'b1;

   localparam logic [LIMIT_W-1:0] LEN_LIMIT_RESET = 3'd4;

   typedef struct packed {
      logic [LIMIT_W-1:0] len_limit;
      logic               nest_en;
   } cfg_type;

   // Control from the parser core to the end-position stack
   typedef struct packed {
      logic               restart;
      logic               commit;
      logic               push;
      logic [WORD_W-1:0]  push_end;
      logic [DEPTH_W-1:0] pop_cnt;
      logic [WORD_W-1:0]  match_pos;
   } stack_cmd_type;

   // Status from the stack back to the core
   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [WORD_W-1:0]  top_end;
      logic [DEPTH_W-1:0] run;
   } stack_stat_type;

   typedef struct packed {
      logic [KIND_W-1:0]      byte_kind;
      logic [BYTE_W-1:0]      byte_out;
      logic [LEVEL_W-1:0]     nest_level;
      logic                   header_done;
      logic [WORD_W-1:0]      tag_value;
      logic [TAG_BYTES_W-1:0] tag_bytes;
      logic                   is_constructed;
      logic [WORD_W-1:0]      value_length;
      logic [LEVEL_W-1:0]     closed_levels;
      logic [ERR_W-1:0]       error_code;
   } result_type;

endpackage

/* hdl/bertlv_ifs.sv */
// Valid/ready channel interfaces for the byte input and the result output.
interface bertlv_req_if;
   import bertlv_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              first_byte;
   logic              last_byte;

   modport source (output valid, data_byte, first_byte, last_byte, input ready);
   modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface bertlv_rsp_if;
   import bertlv_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      byte_kind;
   logic [BYTE_W-1:0]      byte_out;
   logic [LEVEL_W-1:0]     nest_level;
   logic                   header_done;
   logic [WORD_W-1:0]      tag_value;
   logic [TAG_BYTES_W-1:0] tag_bytes;
   logic                   is_constructed;
   logic [WORD_W-1:0]      value_length;
   logic [LEVEL_W-1:0]     closed_levels;
   logic [ERR_W-1:0]       error_code;

   modport source (output valid, byte_kind, byte_out, nest_level, header_done, tag_value,
                   tag_bytes, is_constructed, value_length, closed_levels, error_code,
                   input ready);
   modport sink (input valid, byte_kind, byte_out, nest_level, header_done, tag_value,
                 tag_bytes, is_constructed, value_length, closed_levels, error_code,
                 output ready);
endinterface

/* hdl/bertlv_stack.sv */
// Stack of end positions of the open constructed elements.
module bertlv_stack (
   input  logic                       clock,
   input  logic                       reset,
   input  bertlv_pkg::stack_cmd_type  cmd,
   output bertlv_pkg::stack_stat_type stat
);
   import bertlv_pkg::*;

   logic [WORD_W-1:0]  entry_ff [MAX_DEPTH];
   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] depth_in;
   logic [DEPTH_W-1:0] depth_eff;
   logic [DEPTH_W-1:0] total;
   logic [DEPTH_W-1:0] run;
   logic [WORD_W-1:0]  slot_val;
   logic               still;

   // A new message starts with an empty stack
   assign depth_eff = cmd.restart ? '0 : depth_ff;

   assign stat.depth   = depth_eff;
   assign stat.top_end = entry_ff[IDX_W'(depth_eff - 1'b1)];
   assign stat.run     = run;

   // Count the elements ending at this byte, from the top down,
   // including an element pushed by this byte
   always_comb begin
      total    = depth_eff + DEPTH_W'(cmd.push);
      run      = '0;
      still    = 1'b1;
      slot_val = '0;
      for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
         slot_val = (cmd.push && (DEPTH_W'(i) == depth_eff)) ? cmd.push_end : entry_ff[i];
         if (DEPTH_W'(i) < total) begin
            if (still && (slot_val == cmd.match_pos)) begin
               run = run + 1'b1;
            end else begin
               still = 1'b0;
            end
         end
      end
   end

   assign depth_in = depth_eff + DEPTH_W'(cmd.push) - cmd.pop_cnt;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else if (cmd.commit) begin
         depth_ff <= depth_in;
      end
   end

   // Entries hold no reset: only those below the depth are ever read
   always_ff @(posedge clock) begin
      if (cmd.commit && cmd.push) begin
         entry_ff[IDX_W'(depth_eff)] <= cmd.push_end;
      end
   end

endmodule

/* hdl/bertlv_core.sv */
// Per-byte TLV header decoder, message state and result formation.
module bertlv_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          commit,
   input  logic [bertlv_pkg::BYTE_W-1:0] data_byte,
   input  logic                          first_byte,
   input  logic                          last_byte,
   input  bertlv_pkg::cfg_type           cfg,
   output bertlv_pkg::result_type        result
);
   import bertlv_pkg::*;

   typedef enum logic [2:0] {
      PH_TAG0,
      PH_TAGN,
      PH_LEN0,
      PH_LENN,
      PH_VAL
   } phase_type;

   phase_type             phase_ff, phase_in, phase_a, c_phase;
   logic [WORD_W-1:0]     tag_ff, tag_in, c_tag;
   logic [TAG_CNT_W-1:0]  cnt_ff, cnt_in, c_cnt;
   logic                  cons_ff, cons_in, c_cons;
   logic [WORD_W-1:0]     len_ff, len_in, c_len;
   logic [LEFT_W-1:0]     left_ff, left_in, c_left, left_dec;
   logic [WORD_W-1:0]     pos_ff, pos_in, c_pos;
   logic [WORD_W-1:0]     vend_ff, vend_in, c_vend;
   logic [ERR_W-1:0]      err_ff, err_in, err_a, c_err;

   logic [KIND_W-1:0]     kind;
   logic                  hdr_a;
   logic                  hdr;
   logic                  finish;
   logic                  push;
   logic [6:0]            lcount;
   logic [WORD_W:0]       end_sum;
   logic [WORD_W-1:0]     end_sat;
   logic [DEPTH_W-1:0]    pop_cnt;
   logic [DEPTH_W-1:0]    depth_after;
   logic [LEVEL_W-1:0]    closed;

   stack_cmd_type         stack_cmd;
   stack_stat_type        stack_stat;

   // First byte of a message sees the cleared state
   assign c_phase = first_byte ? PH_TAG0  : phase_ff;
   assign c_tag   = first_byte ? '0       : tag_ff;
   assign c_cnt   = first_byte ? '0       : cnt_ff;
   assign c_cons  = first_byte ? 1'b0     : cons_ff;
   assign c_len   = first_byte ? '0       : len_ff;
   assign c_left  = first_byte ? '0       : left_ff;
   assign c_pos   = first_byte ? '0       : pos_ff;
   assign c_vend  = first_byte ? '0       : vend_ff;
   assign c_err   = first_byte ? ERR_NONE : err_ff;

   assign pos_in   = c_pos + 1'b1;
   assign lcount   = data_byte[6:0];
   assign left_dec = (c_left != '0) ? (c_left - 1'b1) : '0;

   // Header decode
   always_comb begin
      kind    = KIND_SKIP;
      hdr_a   = 1'b0;
      err_a   = c_err;
      phase_a = c_phase;
      tag_in  = c_tag;
      cnt_in  = c_cnt;
      cons_in = c_cons;
      len_in  = c_len;
      left_in = c_left;
      vend_in = c_vend;
      finish  = 1'b0;
      push    = 1'b0;
      if (c_err == ERR_NONE) begin
         case (c_phase)
            PH_TAG0: begin
               kind    = KIND_TAG;
               tag_in  = WORD_W'(data_byte);
               cnt_in  = TAG_CNT_W'(1);
               cons_in = data_byte[5];
               phase_a = (data_byte[4:0] == 5'h1f) ? PH_TAGN : PH_LEN0;
            end
            PH_TAGN: begin
               kind = KIND_TAG;
               if (c_cnt >= TAG_CNT_W'(MAX_TAG_BYTES)) begin
                  err_a = ERR_TAG_LONG;
               end else begin
                  tag_in = {c_tag[WORD_W-BYTE_W-1:0], data_byte};
                  cnt_in = c_cnt + 1'b1;
                  if (!data_byte[7]) begin
                     phase_a = PH_LEN0;
                  end
               end
            end
            PH_LEN0: begin
               kind   = KIND_LENGTH;
               len_in = '0;
               if (!data_byte[7]) begin
                  len_in = WORD_W'(data_byte);
                  finish = 1'b1;
               end else if ((lcount > 7'(cfg.len_limit)) ||
                            (lcount > 7'(MAX_LEN_BYTES))) begin
                  err_a = ERR_LEN_LONG;
               end else if (lcount == '0) begin
                  finish = 1'b1;
               end else begin
                  left_in = LEFT_W'(lcount);
                  phase_a = PH_LENN;
               end
            end
            PH_LENN: begin
               kind    = KIND_LENGTH;
               len_in  = {c_len[WORD_W-BYTE_W-1:0], data_byte};
               left_in = left_dec;
               if (left_dec == '0) begin
                  finish = 1'b1;
               end
            end
            PH_VAL: begin
               kind = KIND_VALUE;
               if (pos_in == c_vend) begin
                  phase_a = PH_TAG0;
               end
            end
            default: begin
               phase_a = PH_TAG0;
            end
         endcase
      end

      // End position of the new element, one adder with carry in
      end_sum = {1'b0, c_pos} + {1'b0, len_in} + (WORD_W+1)'(1);
      end_sat = end_sum[WORD_W] ? '1 : end_sum[WORD_W-1:0];

      // Header complete: check against the parent, then open a level or a value
      if (finish) begin
         if ((stack_stat.depth != '0) && (end_sum > {1'b0, stack_stat.top_end})) begin
            err_a = ERR_OVERRUN;
         end else if (c_cons && cfg.nest_en) begin
            if (stack_stat.depth >= DEPTH_W'(MAX_DEPTH)) begin
               err_a = ERR_TOO_DEEP;
            end else begin
               push    = 1'b1;
               phase_a = PH_TAG0;
               hdr_a   = 1'b1;
            end
         end else begin
            vend_in = end_sat;
            phase_a = (len_in == '0) ? PH_TAG0 : PH_VAL;
            hdr_a   = 1'b1;
         end
      end
   end

   // Level closing and truncation
   always_comb begin
      err_in  = err_a;
      closed  = '0;
      pop_cnt = '0;
      if ((err_a == ERR_NONE) && (stack_stat.run != '0)) begin
         if (phase_a != PH_TAG0) begin
            err_in = ERR_OVERRUN;
         end else begin
            pop_cnt = stack_stat.run;
            closed  = LEVEL_W'(stack_stat.run);
         end
      end
      depth_after = stack_stat.depth + DEPTH_W'(push) - pop_cnt;
      if ((err_in == ERR_NONE) && last_byte &&
          ((phase_a != PH_TAG0) || (depth_after != '0))) begin
         err_in = ERR_TRUNCATED;
      end
      hdr = hdr_a && (err_in == ERR_NONE);
   end

   assign phase_in = phase_a;

   assign stack_cmd.restart   = first_byte;
   assign stack_cmd.commit    = commit;
   assign stack_cmd.push      = push;
   assign stack_cmd.push_end  = end_sat;
   assign stack_cmd.pop_cnt   = pop_cnt;
   assign stack_cmd.match_pos = pos_in;

   bertlv_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stack_cmd),
      .stat  (stack_stat)
   );

   // Result of this byte
   assign result.byte_kind      = kind;
   assign result.byte_out       = data_byte;
   assign result.nest_level     = LEVEL_W'(stack_stat.depth);
   assign result.header_done    = hdr;
   assign result.tag_value      = hdr ? tag_in : '0;
   assign result.tag_bytes      = hdr ? TAG_BYTES_W'(cnt_in) : '0;
   assign result.is_constructed = hdr ? cons_in : 1'b0;
   assign result.value_length   = hdr ? len_in : '0;
   assign result.closed_levels  = closed;
   assign result.error_code     = err_in;

   // Message state, advanced once per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG0;
         tag_ff   <= '0;
         cnt_ff   <= '0;
         cons_ff  <= 1'b0;
         len_ff   <= '0;
         left_ff  <= '0;
         pos_ff   <= '0;
         vend_ff  <= '0;
         err_ff   <= ERR_NONE;
      end else if (commit) begin
         phase_ff <= phase_in;
         tag_ff   <= tag_in;
         cnt_ff   <= cnt_in;
         cons_ff  <= cons_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         pos_ff   <= pos_in;
         vend_ff  <= vend_in;
         err_ff   <= err_in;
      end
   end

endmodule

/* hdl/ber_tlv_stream_parser.sv */
// Top level of the BER-TLV stream parser: channel registers, settings, core.
//
//   channel  direction  carries
//   req_bus  in         data_byte, first_byte, last_byte (one message byte)
//   rsp_bus  out        byte class, header fields, closed levels, error code
//   csr_*    in         write-only settings: length byte limit, nesting on
//
// One byte per cycle sustained while results are taken; a byte passes through
// the input register, then is decoded into the result register.
// The per-byte header decode, end-position add and stack compare set the cycle.
// Reset is synchronous; the stack of end positions needs no clearing pass.
// A stalled result holds; the input register still takes a byte while the
// result register is full, and stalls upstream only when both are occupied
// and the result is not taken.
module ber_tlv_stream_parser (
   input  logic                              clock,
   input  logic                              reset,
   bertlv_req_if.sink                        req_bus,
   bertlv_rsp_if.source                      rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [bertlv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bertlv_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import bertlv_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_first_ff;
   logic              in_last_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        result_ff;
   result_type        result;
   cfg_type           cfg_ff, cfg_in;
   logic              req_xfer;
   logic              advance;

   // Handshake: move a byte from the input register into the result register
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !in_valid_ff || advance;
   assign req_xfer       = req_bus.valid && req_bus.ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff  <= req_bus.data_byte;
         in_first_ff <= req_bus.first_byte;
         in_last_ff  <= req_bus.last_byte;
      end
   end

   // Settings
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LEN_LIMIT: cfg_in.len_limit = csr_wr_data;
            CSR_NEST_EN:   cfg_in.nest_en   = csr_wr_data[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.len_limit <= LEN_LIMIT_RESET;
         cfg_ff.nest_en   <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bertlv_core u_core (
      .clock      (clock),
      .reset      (reset),
      .commit     (advance),
      .data_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .last_byte  (in_last_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.byte_kind      = result_ff.byte_kind;
   assign rsp_bus.byte_out       = result_ff.byte_out;
   assign rsp_bus.nest_level     = result_ff.nest_level;
   assign rsp_bus.header_done    = result_ff.header_done;
   assign rsp_bus.tag_value      = result_ff.tag_value;
   assign rsp_bus.tag_bytes      = result_ff.tag_bytes;
   assign rsp_bus.is_constructed = result_ff.is_constructed;
   assign rsp_bus.value_length   = result_ff.value_length;
   assign rsp_bus.closed_levels  = result_ff.closed_levels;
   assign rsp_bus.error_code     = result_ff.error_code;

endmodule
